// ===== sv/ftpq_pkg.sv =====
// Package for the finish-time priority queue: sizes, codes, entry type and helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ftpq_pkg;

  localparam int DEPTH     = 16;
  localparam int TIME_BITS = 16;
  localparam int ID_BITS   = 16;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int KW        = TIME_BITS + 1;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] arrive;
    logic [TIME_BITS-1:0] need;
  } entry_t;

  localparam int EW = $bits(entry_t);

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_INS,
    S_PLD
  } state_e;

  function automatic logic [KW-1:0] key_of(entry_t e);
    key_of = {1'b0, e.arrive} + {1'b0, e.need};
  endfunction

  // logical slot -> RAM address, wrapping around the ring
  function automatic logic [AW-1:0] phys(logic [AW-1:0] head, logic [CW-1:0] l);
    logic [CW:0] sum;
    sum = (CW + 1)'(head) + (CW + 1)'(l);
    if (sum >= (CW + 1)'(DEPTH)) begin
      sum = sum - (CW + 1)'(DEPTH);
    end
    phys = sum[AW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/ftpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ftpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/finish_time_priority_queue.sv =====
// Finish-time priority queue: sorted ring of entries in RAM, one insertion step at a time.
// Depends on ftpq_pkg and ftpq_ram.
// Full push, push into empty, empty pop and pop to empty finish in S_IDLE; other pops
// load the new head in S_PLD; other pushes run S_CMP, one compare-and-shift step per
// entry passed, and S_INS if all are passed. Next request accepted by the done_o cycle.
// Result shows for one cycle with done_o; receiver cannot stall. Reset empties the queue.
`timescale 1ns / 1ps
`default_nettype none
module finish_time_priority_queue (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  output logic                                done_o,
  input  wire logic                           cmd_i,
  input  wire logic [ftpq_pkg::TIME_BITS-1:0] arrive_time_i,
  input  wire logic [ftpq_pkg::TIME_BITS-1:0] need_time_i,
  input  wire logic [ftpq_pkg::ID_BITS-1:0]   entry_id_i,
  output logic      [1:0]                     status_o,
  output logic      [ftpq_pkg::CW-1:0]        count_o,
  output logic      [ftpq_pkg::ID_BITS-1:0]   removed_id_o,
  output logic      [ftpq_pkg::TIME_BITS-1:0] removed_arrive_o,
  output logic      [ftpq_pkg::TIME_BITS-1:0] removed_need_o,
  output logic                                head_valid_o,
  output logic      [ftpq_pkg::ID_BITS-1:0]   head_id_o,
  output logic      [ftpq_pkg::TIME_BITS-1:0] head_arrive_o,
  output logic      [ftpq_pkg::TIME_BITS-1:0] head_need_o
);

  localparam int AW = ftpq_pkg::AW;
  localparam int CW = ftpq_pkg::CW;

  ftpq_pkg::state_e state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    head_q, head_d;
  ftpq_pkg::entry_t hd_q, hd_d;
  ftpq_pkg::entry_t new_q, new_d;
  logic             done_q;

  logic              fin;
  ftpq_pkg::status_e fin_status;
  logic              fin_pop;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  ftpq_pkg::entry_t wdata, rdata;
  ftpq_pkg::entry_t in_entry;

  logic [1:0]       res_status_q;
  logic [CW-1:0]    res_count_q;
  ftpq_pkg::entry_t res_rem_q;
  logic             res_hv_q;
  ftpq_pkg::entry_t res_head_q;

  assign in_entry = '{id: entry_id_i, arrive: arrive_time_i, need: need_time_i};

  ftpq_ram #(
    .WIDTH(ftpq_pkg::EW),
    .DEPTH(ftpq_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    head_d     = head_q;
    hd_d       = hd_q;
    new_d      = new_q;
    fin        = 1'b0;
    fin_status = ftpq_pkg::ST_DONE;
    fin_pop    = 1'b0;
    we         = 1'b0;
    waddr      = ftpq_pkg::phys(head_q, idx_q);
    wdata      = new_q;
    raddr      = ftpq_pkg::phys(head_q, idx_q - CW'(1));
    case (state_q)
      ftpq_pkg::S_IDLE: begin
        if (start_i) begin
          if (cmd_i == ftpq_pkg::CMD_PUSH) begin
            if (cnt_q == CW'(ftpq_pkg::DEPTH)) begin
              fin        = 1'b1;
              fin_status = ftpq_pkg::ST_FULL;
            end else if (cnt_q == '0) begin
              we     = 1'b1;
              waddr  = ftpq_pkg::phys(head_q, '0);
              wdata  = in_entry;
              hd_d   = in_entry;
              cnt_d  = CW'(1);
              fin    = 1'b1;
            end else begin
              new_d   = in_entry;
              idx_d   = cnt_q;
              raddr   = ftpq_pkg::phys(head_q, cnt_q - CW'(1));
              state_d = ftpq_pkg::S_CMP;
            end
          end else begin
            if (cnt_q == '0) begin
              fin        = 1'b1;
              fin_status = ftpq_pkg::ST_EMPTY;
            end else begin
              fin_pop = 1'b1;
              cnt_d   = cnt_q - CW'(1);
              head_d  = (head_q == AW'(ftpq_pkg::DEPTH - 1)) ? '0 : head_q + AW'(1);
              raddr   = ftpq_pkg::phys(head_q, CW'(1));
              if (cnt_q == CW'(1)) begin
                fin = 1'b1;
              end else begin
                fin_pop = 1'b0;
                state_d = ftpq_pkg::S_PLD;
              end
            end
          end
        end
      end
      ftpq_pkg::S_CMP: begin
        we = 1'b1;
        if (ftpq_pkg::key_of(rdata) <= ftpq_pkg::key_of(new_q)) begin
          wdata   = new_q;
          cnt_d   = cnt_q + CW'(1);
          fin     = 1'b1;
          state_d = ftpq_pkg::S_IDLE;
        end else begin
          wdata = rdata;
          idx_d = idx_q - CW'(1);
          raddr = ftpq_pkg::phys(head_q, idx_q - CW'(2));
          if (idx_q == CW'(1)) begin
            state_d = ftpq_pkg::S_INS;
          end
        end
      end
      ftpq_pkg::S_INS: begin
        we      = 1'b1;
        waddr   = ftpq_pkg::phys(head_q, '0);
        wdata   = new_q;
        hd_d    = new_q;
        cnt_d   = cnt_q + CW'(1);
        fin     = 1'b1;
        state_d = ftpq_pkg::S_IDLE;
      end
      ftpq_pkg::S_PLD: begin
        hd_d    = rdata;
        fin     = 1'b1;
        fin_pop = 1'b1;
        state_d = ftpq_pkg::S_IDLE;
      end
      default: begin
        state_d = ftpq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftpq_pkg::S_IDLE;
      cnt_q   <= '0;
      head_q  <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      head_q  <= head_d;
      idx_q   <= idx_d;
      done_q  <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    hd_q  <= hd_d;
    new_q <= new_d;
    if (fin) begin
      res_status_q <= fin_status;
      res_count_q  <= cnt_d;
      res_rem_q    <= fin_pop ? hd_q : '0;
      res_hv_q     <= (cnt_d != '0);
      res_head_q   <= (cnt_d != '0) ? hd_d : '0;
    end
  end

  assign busy_o           = (state_q != ftpq_pkg::S_IDLE);
  assign done_o           = done_q;
  assign status_o         = res_status_q;
  assign count_o          = res_count_q;
  assign removed_id_o     = res_rem_q.id;
  assign removed_arrive_o = res_rem_q.arrive;
  assign removed_need_o   = res_rem_q.need;
  assign head_valid_o     = res_hv_q;
  assign head_id_o        = res_head_q.id;
  assign head_arrive_o    = res_head_q.arrive;
  assign head_need_o      = res_head_q.need;

endmodule
`default_nettype wire

// ===== verif/ftpq_order_checker.sv =====
// Checker for the finish-time priority queue: keeps a shadow sorted queue, predicts each
// command's report and compares it field by field with what the block returns.
// Depends on ftpq_pkg.
`timescale 1ns / 1ps
module ftpq_order_checker
  import ftpq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_o,
  input  logic                 done_o,
  input  logic                 cmd_i,
  input  logic [TIME_BITS-1:0] arrive_time_i,
  input  logic [TIME_BITS-1:0] need_time_i,
  input  logic [ID_BITS-1:0]   entry_id_i,
  input  logic [1:0]           status_o,
  input  logic [CW-1:0]        count_o,
  input  logic [ID_BITS-1:0]   removed_id_o,
  input  logic [TIME_BITS-1:0] removed_arrive_o,
  input  logic [TIME_BITS-1:0] removed_need_o,
  input  logic                 head_valid_o,
  input  logic [ID_BITS-1:0]   head_id_o,
  input  logic [TIME_BITS-1:0] head_arrive_o,
  input  logic [TIME_BITS-1:0] head_need_o,
  output int                   mismatches,
  output int                   outstanding,
  output int                   dropped_pushes,
  output int                   empty_pops
);

  typedef struct packed {
    status_e       status;
    logic [CW-1:0] count;
    entry_t        removed;
    logic          head_valid;
    entry_t        head;
  } queue_report_t;

  entry_t        shadow[DEPTH];
  int            held;
  queue_report_t due_reports[$];
  queue_report_t want;
  queue_report_t got;
  entry_t        req_entry;
  int            seen;

  function automatic queue_report_t apply_command(cmd_e op, entry_t item);
    queue_report_t r;
    logic [KW-1:0] item_key;
    int            pos;
    r = '0;
    r.status = ST_DONE;
    if (op == CMD_PUSH) begin
      if (held >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        item_key = {1'b0, item.arrive} + {1'b0, item.need};
        pos = 0;
        while (pos < held &&
               ({1'b0, shadow[pos].arrive} + {1'b0, shadow[pos].need}) <= item_key) begin
          pos++;
        end
        for (int i = held; i > pos; i--) begin
          shadow[i] = shadow[i-1];
        end
        shadow[pos] = item;
        held++;
      end
    end else if (held == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.removed = shadow[0];
      for (int i = 1; i < held; i++) begin
        shadow[i-1] = shadow[i];
      end
      held--;
    end
    r.count = held[CW-1:0];
    if (held > 0) begin
      r.head_valid = 1'b1;
      r.head = shadow[0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held = 0;
      due_reports.delete();
      mismatches = 0;
      outstanding = 0;
      dropped_pushes = 0;
      empty_pops = 0;
      seen = 0;
    end else begin
      if (done_o) begin
        got.status = status_e'(status_o);
        got.count = count_o;
        got.removed = '{id: removed_id_o, arrive: removed_arrive_o, need: removed_need_o};
        got.head_valid = head_valid_o;
        got.head = '{id: head_id_o, arrive: head_arrive_o, need: head_need_o};
        if (due_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] result %0d arrived with no request pending", $realtime, seen);
          end
        end else begin
          want = due_reports.pop_front();
          if (got.status !== want.status || got.count !== want.count ||
              got.removed !== want.removed || got.head_valid !== want.head_valid ||
              got.head !== want.head) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result %0d mismatch", $realtime, seen);
              $display("  want status=%0d count=%0d removed=%h/%h/%h head=%0b %h/%h/%h",
                       want.status, want.count, want.removed.id, want.removed.arrive,
                       want.removed.need, want.head_valid, want.head.id, want.head.arrive,
                       want.head.need);
              $display("  got  status=%0d count=%0d removed=%h/%h/%h head=%0b %h/%h/%h",
                       got.status, got.count, got.removed.id, got.removed.arrive,
                       got.removed.need, got.head_valid, got.head.id, got.head.arrive,
                       got.head.need);
            end
          end
        end
        seen++;
      end
      if (start_i && !busy_o) begin
        req_entry = '{id: entry_id_i, arrive: arrive_time_i, need: need_time_i};
        want = apply_command(cmd_e'(cmd_i), req_entry);
        if (want.status == ST_FULL) dropped_pushes++;
        if (want.status == ST_EMPTY) empty_pops++;
        due_reports.push_back(want);
      end
      outstanding = due_reports.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the priority queue testbench: clock, reset, request stimulus, watchdog, verdict.
// Depends on ftpq_pkg, finish_time_priority_queue and ftpq_order_checker.
`timescale 1ns / 1ps
module testbench;
  import ftpq_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_REQUESTS = 950;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 cmd_i = 1'b0;
  logic [TIME_BITS-1:0] arrive_time_i = '0;
  logic [TIME_BITS-1:0] need_time_i = '0;
  logic [ID_BITS-1:0]   entry_id_i = '0;
  logic                 busy_o;
  logic                 done_o;
  logic [1:0]           status_o;
  logic [CW-1:0]        count_o;
  logic [ID_BITS-1:0]   removed_id_o;
  logic [TIME_BITS-1:0] removed_arrive_o;
  logic [TIME_BITS-1:0] removed_need_o;
  logic                 head_valid_o;
  logic [ID_BITS-1:0]   head_id_o;
  logic [TIME_BITS-1:0] head_arrive_o;
  logic [TIME_BITS-1:0] head_need_o;

  int mismatches;
  int outstanding;
  int dropped_pushes;
  int empty_pops;
  int requests_sent = 0;
  int quiet_cycles = 0;
  bit gaps_on = 1'b1;

  finish_time_priority_queue dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .done_o          (done_o),
    .cmd_i           (cmd_i),
    .arrive_time_i   (arrive_time_i),
    .need_time_i     (need_time_i),
    .entry_id_i      (entry_id_i),
    .status_o        (status_o),
    .count_o         (count_o),
    .removed_id_o    (removed_id_o),
    .removed_arrive_o(removed_arrive_o),
    .removed_need_o  (removed_need_o),
    .head_valid_o    (head_valid_o),
    .head_id_o       (head_id_o),
    .head_arrive_o   (head_arrive_o),
    .head_need_o     (head_need_o)
  );

  ftpq_order_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .done_o          (done_o),
    .cmd_i           (cmd_i),
    .arrive_time_i   (arrive_time_i),
    .need_time_i     (need_time_i),
    .entry_id_i      (entry_id_i),
    .status_o        (status_o),
    .count_o         (count_o),
    .removed_id_o    (removed_id_o),
    .removed_arrive_o(removed_arrive_o),
    .removed_need_o  (removed_need_o),
    .head_valid_o    (head_valid_o),
    .head_id_o       (head_id_o),
    .head_arrive_o   (head_arrive_o),
    .head_need_o     (head_need_o),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .dropped_pushes  (dropped_pushes),
    .empty_pops      (empty_pops)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // small values make equal finish keys common
  function automatic logic [TIME_BITS-1:0] pick_time();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return TIME_BITS'($urandom_range(7));
    if (roll < 40) return (roll < 35) ? '0 : '1;
    return TIME_BITS'($urandom);
  endfunction

  task automatic issue(input cmd_e op, input logic [TIME_BITS-1:0] arrive,
                       input logic [TIME_BITS-1:0] need, input logic [ID_BITS-1:0] id);
    int gap;
    gap = 0;
    if (gaps_on) begin
      while ($urandom_range(99) < 36) gap++;
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= op;
    arrive_time_i <= arrive;
    need_time_i <= need;
    entry_id_i <= id;
    do @(posedge clk_i); while (busy_o);
    requests_sent++;
  endtask

  initial begin
    int mode;
    int run_left;
    int push_pct;
    mode = 0;
    run_left = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pop, key extremes, equal keys incl. carry into bit 16
    issue(CMD_POP, '1, '1, '1);
    issue(CMD_PUSH, '1, '1, '1);
    issue(CMD_PUSH, '0, '0, '0);
    issue(CMD_PUSH, 16'h8000, 16'h0000, 16'h0001);
    issue(CMD_PUSH, 16'h0000, 16'h8000, 16'h0002);
    issue(CMD_PUSH, 16'h4000, 16'h4000, 16'h0003);
    issue(CMD_PUSH, 16'h7fff, 16'h0001, 16'h0004);
    issue(CMD_PUSH, 16'hffff, 16'h0001, 16'h0005);
    issue(CMD_PUSH, 16'h8000, 16'h8000, 16'h0006);
    repeat (9) issue(CMD_POP, '0, '0, '0);
    issue(CMD_POP, 16'h5555, 16'haaaa, 16'h5a5a);

    // random: runs that fill to the top, drain to empty, or hover
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      if (run_left == 0) begin
        mode = $urandom_range(2);
        run_left = $urandom_range(30, 110);
      end
      run_left--;
      gaps_on = !(k >= 400 && k < 600);
      push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      if ($urandom_range(99) < push_pct) begin
        issue(CMD_PUSH, pick_time(), pick_time(), ID_BITS'($urandom));
      end else begin
        issue(CMD_POP, TIME_BITS'($urandom), TIME_BITS'($urandom), ID_BITS'($urandom));
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d requests sent: directed key extremes and ties, then fill/drain/hover runs",
             requests_sent);
    $display("%0d pushes dropped on a full queue, %0d pops of an empty queue",
             dropped_pushes, empty_pops);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ftpq_pkg.sv
sv/ftpq_ram.sv
sv/finish_time_priority_queue.sv
verif/ftpq_order_checker.sv
verif/testbench.sv
